// ===== rtl/siph_pkg.sv =====
// shared types and constants of the siphash-2-4 keyed hash
// no dependencies; imported by siph_round and siphash_2_4_keyed_hash
package siph_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned NB_W    = 4;
  localparam int unsigned LEN_W   = 8;

  localparam logic [WORD_W-1:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [WORD_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [WORD_W-1:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [WORD_W-1:0] SIP_C3 = 64'h7465646279746573;
  localparam logic [WORD_W-1:0] SIP_FINAL_XOR = 64'h00000000000000ff;

  localparam logic [NB_W-1:0] FULL_BYTES = 4'd8;

  typedef struct packed {
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] v2;
    logic [WORD_W-1:0] v3;
  } lanes_t;

endpackage

// ===== rtl/siph_round.sv =====
// one sipround over the four lanes, the shared unit of the sequencer
// depends on siph_pkg
module siph_round (
  input  siph_pkg::lanes_t lanes_in,
  output siph_pkg::lanes_t lanes_out
);
  import siph_pkg::*;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input int unsigned r);
    rotl = (x << r) | (x >> (WORD_W - r));
  endfunction

  logic [WORD_W-1:0] a0, a1, a2, a3;
  logic [WORD_W-1:0] b0, b1, b2, b3;

  always_comb begin
    a0 = lanes_in.v0 + lanes_in.v1;
    a1 = rotl(lanes_in.v1, 13) ^ a0;
    a0 = rotl(a0, 32);
    a2 = lanes_in.v2 + lanes_in.v3;
    a3 = rotl(lanes_in.v3, 16) ^ a2;
    b0 = a0 + a3;
    b3 = rotl(a3, 21) ^ b0;
    b2 = a2 + a1;
    b1 = rotl(a1, 17) ^ b2;
    b2 = rotl(b2, 32);
    lanes_out = '{v0: b0, v1: b1, v2: b2, v3: b3};
  end

endmodule

// ===== rtl/siphash_2_4_keyed_hash.sv =====
// SipHash-2-4 keyed hash: one 64-bit message word per item, one hash item per message.
// A single shared sipround unit runs one round per cycle under a small sequencer:
// a word that is not last takes an accept plus two rounds; the last word also takes
// an accept plus two rounds, then two more for an extra length block when it is a full
// word, then four finalisation rounds, and then a move of the hash into the output
// register. The key is read from the configuration registers at the first word of
// each message. Depends on siph_pkg and siph_round.
module siphash_2_4_keyed_hash (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_addr,
  input  logic [siph_pkg::WORD_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [siph_pkg::WORD_W-1:0]   in_msg_word,
  input  logic [siph_pkg::NB_W-1:0]     in_word_bytes,
  input  logic                          in_last_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [siph_pkg::WORD_W-1:0]   out_hash_value
);
  import siph_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MIX   = 4'b0010,
    S_FINAL = 4'b0100,
    S_HOLD  = 4'b1000
  } state_t;

  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  state_t            state_r, state_nxt;
  logic [1:0]        rnd_cnt_r, rnd_cnt_nxt;
  lanes_t            v_r, v_nxt;
  lanes_t            base_v, rnd_out;
  logic [WORD_W-1:0] key_low_r, key_high_r;
  logic [WORD_W-1:0] m_r, m_nxt;
  logic [WORD_W-1:0] fin_r, fin_nxt;
  logic              fin_pend_r, fin_pend_nxt;
  logic              last_r, last_nxt;
  logic              in_msg_r, in_msg_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_hash_r, out_hash_nxt;

  logic              in_acc;
  logic [NB_W-1:0]   nb_c;
  logic [LEN_W-1:0]  len_base, len_new;
  logic [WORD_W-1:0] byte_mask, fin_c;

  siph_round u_round (
    .lanes_in  (v_r),
    .lanes_out (rnd_out)
  );

  assign in_ready       = (state_r == S_IDLE);
  assign in_acc         = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
        CFG_KEY_HIGH: key_high_r <= cfg_wdata;
        default:      key_low_r  <= key_low_r;
      endcase
    end
  end

  // padded final block, running length and starting lanes
  always_comb begin
    nb_c = (in_word_bytes > FULL_BYTES) ? FULL_BYTES : in_word_bytes;
    for (int i = 0; i < WORD_W / 8; i++) begin
      byte_mask[i*8 +: 8] = (NB_W'(i) < nb_c) ? 8'hff : 8'h00;
    end
    len_base = in_msg_r ? len_r : '0;
    len_new  = len_base + (in_last_word ? LEN_W'(nb_c) : LEN_W'(FULL_BYTES));
    fin_c    = {len_new, {(WORD_W-LEN_W){1'b0}}};
    if (nb_c != FULL_BYTES) begin
      fin_c = fin_c | (in_msg_word & byte_mask);
    end
    if (in_msg_r) begin
      base_v = v_r;
    end else begin
      base_v = '{v0: key_low_r ^ SIP_C0, v1: key_high_r ^ SIP_C1,
                 v2: key_low_r ^ SIP_C2, v3: key_high_r ^ SIP_C3};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rnd_cnt_nxt   = rnd_cnt_r;
    v_nxt         = v_r;
    m_nxt         = m_r;
    fin_nxt       = fin_r;
    fin_pend_nxt  = fin_pend_r;
    last_nxt      = last_r;
    in_msg_nxt    = in_msg_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_hash_nxt  = out_hash_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          v_nxt       = base_v;
          fin_nxt     = fin_c;
          last_nxt    = in_last_word;
          in_msg_nxt  = !in_last_word;
          len_nxt     = in_last_word ? '0 : len_new;
          rnd_cnt_nxt = '0;
          state_nxt   = S_MIX;
          if (in_last_word && (nb_c != FULL_BYTES)) begin
            m_nxt        = fin_c;
            v_nxt.v3     = base_v.v3 ^ fin_c;
            fin_pend_nxt = 1'b0;
          end else begin
            m_nxt        = in_msg_word;
            v_nxt.v3     = base_v.v3 ^ in_msg_word;
            fin_pend_nxt = in_last_word;
          end
        end
      end
      S_MIX: begin
        v_nxt       = rnd_out;
        rnd_cnt_nxt = rnd_cnt_r + 2'd1;
        if (rnd_cnt_r == 2'd1) begin
          v_nxt.v0    = rnd_out.v0 ^ m_r;
          rnd_cnt_nxt = '0;
          priority if (fin_pend_r) begin
            m_nxt        = fin_r;
            v_nxt.v3     = rnd_out.v3 ^ fin_r;
            fin_pend_nxt = 1'b0;
          end else if (last_r) begin
            v_nxt.v2  = rnd_out.v2 ^ SIP_FINAL_XOR;
            state_nxt = S_FINAL;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FINAL: begin
        v_nxt       = rnd_out;
        rnd_cnt_nxt = rnd_cnt_r + 2'd1;
        if (rnd_cnt_r == 2'd3) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = v_r.v0 ^ v_r.v1 ^ v_r.v2 ^ v_r.v3;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rnd_cnt_r   <= '0;
      fin_pend_r  <= 1'b0;
      last_r      <= 1'b0;
      in_msg_r    <= 1'b0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_cnt_r   <= rnd_cnt_nxt;
      fin_pend_r  <= fin_pend_nxt;
      last_r      <= last_nxt;
      in_msg_r    <= in_msg_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    m_r        <= m_nxt;
    fin_r      <= fin_nxt;
    out_hash_r <= out_hash_nxt;
  end

  a_final_after_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIX && state_nxt == S_FINAL) |-> (last_r && !fin_pend_r))
    else $error("finalisation entered with padding block outstanding");

  a_mix_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIX) |-> (rnd_cnt_r <= 2'd1))
    else $error("compression round count out of range");

  a_result_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_HOLD))
    else $error("result item raised outside hold");

  a_msg_open: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_last_word) |=> (in_msg_r && state_r == S_MIX))
    else $error("message not open after non-last item");

endmodule
